// ===== hw/rtl/deq_pkg.sv =====
// deq_pkg: shared sizes, operation codes, status codes and structs for the deque unit
// no dependencies; imported by every module of the deque unit
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   // store and field sizes
   localparam int DEPTH      = 16;
   localparam int ADDR_BITS  = 4;
   localparam int OCC_BITS   = 5;
   localparam int WORD_BITS  = 32;
   localparam int INDEX_BITS = 8;
   localparam int KIND_BITS  = 4;
   localparam int STAT_BITS  = 2;

   // request kinds as they arrive on the bus
   localparam logic [KIND_BITS-1:0] KIND_PUSH_LEFT  = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_PUSH_RIGHT = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_POP_LEFT   = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_POP_RIGHT  = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_PEEK_LEFT  = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_PEEK_RIGHT = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_READ_CUR   = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_CUR_LEFT   = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_CUR_RIGHT  = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_SET_CUR    = 4'd9;

   // result status codes
   localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd2;
   localparam logic [STAT_BITS-1:0] STAT_END   = 2'd3;

   // decoded operation
   typedef enum logic [3:0] {
      OP_PUSH_L,
      OP_PUSH_R,
      OP_POP_L,
      OP_POP_R,
      OP_PEEK_L,
      OP_PEEK_R,
      OP_READ_CUR,
      OP_CUR_L,
      OP_CUR_R,
      OP_SET_CUR,
      OP_NOP
   } op_code_type;

   // one queued operation
   typedef struct packed {
      op_code_type                  code;
      logic signed [WORD_BITS-1:0]  value;
      logic [INDEX_BITS-1:0]        index;
   } op_type;

   // one result transaction
   typedef struct packed {
      logic signed [WORD_BITS-1:0]  value;
      logic [STAT_BITS-1:0]         status;
      logic [OCC_BITS-1:0]          fill_count;
      logic                         is_empty;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/deq_front.sv =====
// deq_front: accepts request transactions and decodes the kind into an operation
// depends on deq_pkg; feeds deq_queue
`timescale 1ns / 1ps
`default_nettype none

module deq_front (
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [deq_pkg::WORD_BITS+deq_pkg::INDEX_BITS-1:0] req_tdata,
   input  wire logic [deq_pkg::KIND_BITS-1:0]    req_tuser,
   output logic                                  op_valid,
   input  wire logic                             op_ready,
   output deq_pkg::op_type                       op
);
   import deq_pkg::*;

   op_code_type code;

   // kind to operation, unused kinds become a no-op
   always_comb begin
      unique case (req_tuser)
         KIND_PUSH_LEFT:  code = OP_PUSH_L;
         KIND_PUSH_RIGHT: code = OP_PUSH_R;
         KIND_POP_LEFT:   code = OP_POP_L;
         KIND_POP_RIGHT:  code = OP_POP_R;
         KIND_PEEK_LEFT:  code = OP_PEEK_L;
         KIND_PEEK_RIGHT: code = OP_PEEK_R;
         KIND_READ_CUR:   code = OP_READ_CUR;
         KIND_CUR_LEFT:   code = OP_CUR_L;
         KIND_CUR_RIGHT:  code = OP_CUR_R;
         KIND_SET_CUR:    code = OP_SET_CUR;
         default:         code = OP_NOP;
      endcase
   end

   // unpack payload and pass the handshake through to the queue
   always_comb begin
      op.code    = code;
      op.value   = req_tdata[WORD_BITS-1:0];
      op.index   = req_tdata[WORD_BITS+INDEX_BITS-1:WORD_BITS];
      op_valid   = req_tvalid;
      req_tready = op_ready;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/deq_queue.sv =====
// deq_queue: two-entry operation queue between the front and back parts
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

module deq_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_valid,
   output logic                 wr_ready,
   input  wire deq_pkg::op_type wr_data,
   output logic                 rd_valid,
   input  wire logic            rd_ready,
   output deq_pkg::op_type      rd_data
);
   import deq_pkg::*;

   op_type      slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_wr, do_rd;

   // handshake and pointer updates
   always_comb begin
      wr_ready  = (count_ff != 2'd2);
      rd_valid  = (count_ff != 2'd0);
      rd_data   = slot_ff[rd_ptr_ff];
      do_wr     = wr_valid && wr_ready;
      do_rd     = rd_valid && rd_ready;
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/deq_back.sv =====
// deq_back: executes queued operations on the ring store, ends and cursor
// depends on deq_pkg; holds the word memory and the result register
`timescale 1ns / 1ps
`default_nettype none

module deq_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            op_valid,
   output logic                 op_ready,
   input  wire deq_pkg::op_type op,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output deq_pkg::rsp_type     rsp
);
   import deq_pkg::*;

   typedef enum logic {
      B_IDLE,
      B_READ
   } back_state_type;

   back_state_type              state_ff;
   logic [ADDR_BITS-1:0]        left_ff, left_in;
   logic [OCC_BITS-1:0]         occ_ff, occ_in;
   logic [ADDR_BITS-1:0]        cur_ff, cur_in;
   logic [STAT_BITS-1:0]        pend_status_ff;
   logic                        out_valid_ff, out_valid_in;
   rsp_type                     out_ff;

   logic signed [WORD_BITS-1:0] mem [DEPTH];
   logic signed [WORD_BITS-1:0] rd_data_ff;

   logic                        out_free;
   logic                        take;
   logic                        empty, full;
   logic [OCC_BITS-1:0]         occ_m1, occ_m2, cur_p1;
   logic [ADDR_BITS-1:0]        read_off;
   logic [STAT_BITS-1:0]        status;
   logic                        need_read;
   logic                        wr_en;
   logic [ADDR_BITS-1:0]        wr_addr;
   logic [ADDR_BITS-1:0]        rd_addr;
   logic                        idx_over;

   // a new operation is taken when idle and the result slot frees up
   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      take     = (state_ff == B_IDLE) && op_valid && out_free;
      op_ready = take;
      empty    = (occ_ff == '0);
      full     = occ_ff[OCC_BITS-1];
      occ_m1   = occ_ff - OCC_BITS'(1);
      occ_m2   = occ_ff - OCC_BITS'(2);
      cur_p1   = {1'b0, cur_ff} + OCC_BITS'(1);
      idx_over = (op.index >= {{(INDEX_BITS-OCC_BITS){1'b0}}, occ_ff});
   end

   // next state of ends and cursor, store access and status
   always_comb begin
      left_in   = left_ff;
      occ_in    = occ_ff;
      cur_in    = cur_ff;
      status    = STAT_OK;
      need_read = 1'b0;
      read_off  = '0;
      wr_en     = 1'b0;
      wr_addr   = left_ff + occ_ff[ADDR_BITS-1:0];
      unique case (op.code)
         OP_PUSH_L, OP_PUSH_R: begin
            if (full) begin
               status = STAT_FULL;
            end else begin
               wr_en  = 1'b1;
               occ_in = occ_ff + OCC_BITS'(1);
               if (op.code == OP_PUSH_L) begin
                  left_in = left_ff - ADDR_BITS'(1);
                  wr_addr = left_ff - ADDR_BITS'(1);
                  cur_in  = empty ? '0 : cur_ff + ADDR_BITS'(1);
               end else begin
                  cur_in  = empty ? '0 : cur_ff;
               end
            end
         end
         OP_POP_L: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else begin
               need_read = 1'b1;
               read_off  = '0;
               left_in   = left_ff + ADDR_BITS'(1);
               occ_in    = occ_m1;
               cur_in    = (cur_ff != '0) ? cur_ff - ADDR_BITS'(1) : '0;
            end
         end
         OP_POP_R: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else begin
               need_read = 1'b1;
               read_off  = occ_m1[ADDR_BITS-1:0];
               occ_in    = occ_m1;
               if (occ_m1 == '0) begin
                  cur_in = '0;
               end else if ({1'b0, cur_ff} >= occ_m1) begin
                  cur_in = occ_m2[ADDR_BITS-1:0];
               end
            end
         end
         OP_PEEK_L, OP_PEEK_R, OP_READ_CUR, OP_CUR_L, OP_CUR_R, OP_SET_CUR: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else begin
               need_read = 1'b1;
               unique case (op.code)
                  OP_PEEK_L:  read_off = '0;
                  OP_PEEK_R:  read_off = occ_m1[ADDR_BITS-1:0];
                  OP_CUR_L: begin
                     if (cur_ff == '0) begin
                        status = STAT_END;
                     end else begin
                        cur_in = cur_ff - ADDR_BITS'(1);
                     end
                     read_off = cur_in;
                  end
                  OP_CUR_R: begin
                     if (cur_p1 >= occ_ff) begin
                        status = STAT_END;
                     end else begin
                        cur_in = cur_p1[ADDR_BITS-1:0];
                     end
                     read_off = cur_in;
                  end
                  OP_SET_CUR: begin
                     cur_in   = idx_over ? occ_m1[ADDR_BITS-1:0] : op.index[ADDR_BITS-1:0];
                     read_off = cur_in;
                  end
                  default: read_off = cur_ff;
               endcase
            end
         end
         default: begin
            status = STAT_OK;
         end
      endcase
      rd_addr = left_ff + read_off;
      // result becomes valid on a no-read take or at the end of a read, else drains
      if (((state_ff == B_IDLE) && take && !need_read) || (state_ff == B_READ)) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   // sequencer, pointers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         left_ff      <= '0;
         occ_ff       <= '0;
         cur_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            B_IDLE: begin
               if (take) begin
                  left_ff <= left_in;
                  occ_ff  <= occ_in;
                  cur_ff  <= cur_in;
                  if (need_read) begin
                     pend_status_ff <= status;
                     state_ff       <= B_READ;
                  end else begin
                     out_ff.value      <= '0;
                     out_ff.status     <= status;
                     out_ff.fill_count <= occ_in;
                     out_ff.is_empty   <= (occ_in == '0);
                  end
               end
            end
            B_READ: begin
               out_ff.value      <= rd_data_ff;
               out_ff.status     <= pend_status_ff;
               out_ff.fill_count <= occ_ff;
               out_ff.is_empty   <= (occ_ff == '0);
               state_ff          <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // word memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (take && wr_en) begin
         mem[wr_addr] <= op.value;
      end
      if (take && need_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/deque_with_cursor_unit.sv =====
// deque_with_cursor_unit: top level of the bounded deque with cursor
// depends on deq_pkg, deq_front, deq_queue and deq_back
//
//   channel | direction | tdata (low bit up)                            | tuser
//   req     | in        | value_in[31:0], index[39:32]                  | kind[3:0]
//   rsp     | out       | value_out[31:0], status[33:32],
//           |           | fill_count[38:34], is_empty[39]               | -
//
// pushes, full pushes, empty-queue errors and unused kinds are answered when taken by the
// back part; pops, peeks and cursor operations wait in B_READ on the registered read port.
// a two-entry queue sits between decode and execution, so requests keep flowing while
// a result waits; a stalled rsp side holds execution but not the first two requests.
// synchronous reset empties the deque at once; no clearing pass over the memory.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_cursor_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // value_in[31:0], index[39:32]
   input  wire logic [3:0]   req_tuser,   // kind[3:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [39:0]       rsp_tdata    // value_out, status, fill_count, is_empty
);
   import deq_pkg::*;

   op_type  front_op, back_op;
   logic    front_valid, front_ready;
   logic    back_valid, back_ready;
   rsp_type rsp;

   // decode incoming transactions
   deq_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (front_valid),
      .op_ready   (front_ready),
      .op         (front_op)
   );

   // decouple decode from execution
   deq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_data  (front_op),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_data  (back_op)
   );

   // execute against the ring store
   deq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (back_valid),
      .op_ready  (back_ready),
      .op        (back_op),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the result, first field lowest
   assign rsp_tdata = {rsp.is_empty, rsp.fill_count, rsp.status, rsp.value};

endmodule

`default_nettype wire

// ===== dv/tb_deque_with_cursor_unit.sv =====
// tb_deque_with_cursor_unit: self-checking testbench for the bounded deque with cursor
// depends on deq_pkg and deque_with_cursor_unit; drives req, checks rsp against a local model
`timescale 1ns / 1ps

module tb_deque_with_cursor_unit;
   import deq_pkg::*;

   // kinds the block ignores
   localparam logic [KIND_BITS-1:0] KIND_UNUSED_HI = 4'd15;
   localparam int RANDOM_OPS     = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 20;
   localparam int TIMEOUT_CYCLES = 200000;

   // one request as queued for the driver
   typedef struct {
      logic [KIND_BITS-1:0]        kind;
      logic signed [WORD_BITS-1:0] word;
      logic [INDEX_BITS-1:0]       idx;
      bit                          drain_first;
   } deque_op_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata  = '0;   // value_in[31:0], index[39:32]
   logic [3:0]        req_tuser  = '0;   // kind[3:0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;         // value_out, status, fill_count, is_empty

   deque_op_type op_backlog[$];
   rsp_type      deque_results_due[$];
   deque_op_type live_op;
   int           total_ops;
   int           ops_accepted;
   int           mismatch_count;

   // model state of the deque
   logic signed [WORD_BITS-1:0] ring_words [DEPTH];
   logic [ADDR_BITS-1:0]        left_pos;
   logic [OCC_BITS-1:0]         occ;
   logic [ADDR_BITS-1:0]        cur_off;

   deque_with_cursor_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // store index of a word counted from the left end, wraps with the ring
   function automatic logic [ADDR_BITS-1:0] ring_slot(input logic [OCC_BITS-1:0] off);
      return left_pos + off[ADDR_BITS-1:0];
   endfunction

   // apply one operation to the model and return the result it yields
   function automatic rsp_type deque_apply(input logic [KIND_BITS-1:0] kind,
                                           input logic signed [WORD_BITS-1:0] word,
                                           input logic [INDEX_BITS-1:0] idx);
      rsp_type r;
      r.value  = '0;
      r.status = STAT_OK;
      case (kind)
         KIND_PUSH_LEFT, KIND_PUSH_RIGHT: begin
            if (occ >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               if (kind == KIND_PUSH_LEFT) begin
                  left_pos = left_pos - 1'b1;
                  ring_words[left_pos] = word;
                  if (occ != 0) cur_off = cur_off + 1'b1;
               end else begin
                  ring_words[ring_slot(occ)] = word;
               end
               if (occ == 0) cur_off = '0;
               occ = occ + 1'b1;
            end
         end
         KIND_POP_LEFT, KIND_POP_RIGHT: begin
            if (occ == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               if (kind == KIND_POP_LEFT) begin
                  r.value  = ring_words[left_pos];
                  left_pos = left_pos + 1'b1;
                  if (cur_off != 0) cur_off = cur_off - 1'b1;
               end else begin
                  r.value = ring_words[ring_slot(occ - 1'b1)];
                  // cursor on the popped right end falls back to the new right end
                  if (occ > 1 && cur_off >= occ - 1) cur_off = ADDR_BITS'(occ - 5'd2);
               end
               occ = occ - 1'b1;
               if (occ == 0) cur_off = '0;
            end
         end
         KIND_PEEK_LEFT, KIND_PEEK_RIGHT, KIND_READ_CUR,
         KIND_CUR_LEFT, KIND_CUR_RIGHT, KIND_SET_CUR: begin
            if (occ == 0) begin
               r.status = STAT_EMPTY;
            end else if (kind == KIND_PEEK_LEFT) begin
               r.value = ring_words[left_pos];
            end else if (kind == KIND_PEEK_RIGHT) begin
               r.value = ring_words[ring_slot(occ - 1'b1)];
            end else begin
               if (kind == KIND_CUR_LEFT) begin
                  if (cur_off == 0) r.status = STAT_END;
                  else cur_off = cur_off - 1'b1;
               end else if (kind == KIND_CUR_RIGHT) begin
                  if (cur_off + 1 >= occ) r.status = STAT_END;
                  else cur_off = cur_off + 1'b1;
               end else if (kind == KIND_SET_CUR) begin
                  cur_off = (idx >= occ) ? ADDR_BITS'(occ - 1'b1) : idx[ADDR_BITS-1:0];
               end
               r.value = ring_words[ring_slot({1'b0, cur_off})];
            end
         end
         default: ;
      endcase
      r.fill_count = occ;
      r.is_empty   = (occ == 0);
      return r;
   endfunction

   // idle percentages per phase: sender busy-ish then receiver, then none
   function automatic int drive_phase();
      int p;
      p = (total_ops == 0) ? 2 : (ops_accepted * 3) / total_ops;
      return (p > 2) ? 2 : p;
   endfunction

   function automatic int send_idle_pct();
      case (drive_phase())
         0:       return 38;
         1:       return 55;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct();
      case (drive_phase())
         0:       return 55;
         1:       return 38;
         default: return 0;
      endcase
   endfunction

   task automatic add_op(input logic [KIND_BITS-1:0] kind, input logic [WORD_BITS-1:0] word,
                         input logic [INDEX_BITS-1:0] idx, input bit drain_first = 1'b0);
      deque_op_type op;
      op.kind        = kind;
      op.word        = word;
      op.idx         = idx;
      op.drain_first = drain_first;
      op_backlog.push_back(op);
   endtask

   function automatic logic [WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [KIND_BITS-1:0] pick_kind(input int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         // fill: mostly pushes so the queue reaches full
         0: if (r < 70) return $urandom_range(0, 1) ? KIND_PUSH_LEFT : KIND_PUSH_RIGHT;
         // drain: mostly pops so the queue runs empty
         1: if (r < 65) return $urandom_range(0, 1) ? KIND_POP_LEFT : KIND_POP_RIGHT;
         // noise: any code, unused ones included
         3: return KIND_BITS'($urandom_range(0, 15));
         default: ;
      endcase
      return KIND_BITS'($urandom_range(KIND_PUSH_LEFT, KIND_SET_CUR));
   endfunction

   // stimulus: directed corner cases, then random bursts
   initial begin
      int mode;
      int burst;
      int n;
      // every access kind on an empty queue
      add_op(KIND_POP_LEFT,   '0, '0);
      add_op(KIND_POP_RIGHT,  '0, '0);
      add_op(KIND_PEEK_LEFT,  '0, '0);
      add_op(KIND_PEEK_RIGHT, '0, '0);
      add_op(KIND_READ_CUR,   '0, '0);
      add_op(KIND_CUR_LEFT,   '0, '0);
      add_op(KIND_CUR_RIGHT,  '0, '0);
      add_op(KIND_SET_CUR,    '0, 8'hff);
      add_op(KIND_UNUSED_HI,  32'hffff_ffff, 8'hff);
      // pushes with extreme words; cursor lands on the first and follows it
      add_op(KIND_PUSH_RIGHT, 32'h7fff_ffff, '0);
      add_op(KIND_PUSH_LEFT,  32'h8000_0000, '0);
      add_op(KIND_PUSH_RIGHT, 32'hffff_ffff, 8'hff);
      add_op(KIND_PUSH_LEFT,  32'h0000_0000, 8'hff);
      add_op(KIND_PEEK_LEFT,  '0, '0);
      add_op(KIND_PEEK_RIGHT, '0, '0);
      add_op(KIND_READ_CUR,   '0, '0);
      // step off both ends
      add_op(KIND_CUR_RIGHT,  '0, '0);
      add_op(KIND_CUR_RIGHT,  '0, '0);
      add_op(KIND_SET_CUR,    '0, 8'h00);
      add_op(KIND_CUR_LEFT,   '0, '0);
      // clamp past the last word, then pop the word under the cursor
      add_op(KIND_SET_CUR,    '0, 8'hff);
      add_op(KIND_POP_RIGHT,  '0, '0);
      add_op(KIND_SET_CUR,    '0, 8'h00);
      add_op(KIND_POP_LEFT,   '0, '0);
      add_op(KIND_POP_LEFT,   '0, '0);
      add_op(KIND_POP_LEFT,   '0, '0);

      n = 0;
      while (n < RANDOM_OPS) begin
         mode  = $urandom_range(0, 3);
         burst = $urandom_range(8, 40);
         repeat (burst) begin
            add_op(pick_kind(mode), pick_word(),
                   INDEX_BITS'($urandom_range(0, 1) ? $urandom_range(0, DEPTH + 1)
                                                    : $urandom_range(0, 255)),
                   (n == RANDOM_OPS / 3) || (n == 2 * RANDOM_OPS / 3));
            n++;
         end
      end
      total_ops = op_backlog.size();
   end

   // request driver: predicts each accepted transaction, then presents the next one
   always @(posedge clock) begin : drive_req
      logic fired;
      fired = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
         left_pos   = '0;
         occ        = '0;
         cur_off    = '0;
      end else begin
         if (fired) begin
            deque_results_due.push_back(deque_apply(live_op.kind, live_op.word, live_op.idx));
            ops_accepted++;
         end
         if (!req_tvalid || fired) begin
            if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct() &&
                !(op_backlog[0].drain_first && deque_results_due.size() != 0)) begin
               live_op = op_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {live_op.idx, live_op.word};
               req_tuser  <= live_op.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compares each rsp transaction with the oldest prediction
   always @(posedge clock) begin : watch_rsp
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value      = rsp_tdata[31:0];
            got.status     = rsp_tdata[33:32];
            got.fill_count = rsp_tdata[38:34];
            got.is_empty   = rsp_tdata[39];
            if (deque_results_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected result value=%0d status=%0d fill=%0d empty=%0b",
                           $realtime, got.value, got.status, got.fill_count, got.is_empty);
            end else begin
               want = deque_results_due.pop_front();
               if (got.value !== want.value || got.status !== want.status ||
                   got.fill_count !== want.fill_count || got.is_empty !== want.is_empty) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"%0t: mismatch exp value=%0d status=%0d fill=%0d empty=%0b",
                               " got value=%0d status=%0d fill=%0d empty=%0b"}, $realtime,
                              want.value, want.status, want.fill_count, want.is_empty,
                              got.value, got.status, got.fill_count, got.is_empty);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct());
      end
   end

   // end of run once every request is in and every result is back
   initial begin
      ops_accepted   = 0;
      mismatch_count = 0;
      @(negedge reset);
      @(posedge clock);
      while (op_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (deque_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_CYCLES * 12);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_front.sv
hw/rtl/deq_queue.sv
hw/rtl/deq_back.sv
hw/rtl/deque_with_cursor_unit.sv
dv/tb_deque_with_cursor_unit.sv
